/* design/i80_pkg.sv */
// Shared types and constants for the 8080 instruction core.
// Holds sequencer states, instruction classes, ALU operations and the flag record.
// No dependencies.
`default_nettype none

package i80_pkg;

  localparam logic [15:0] SP_RESET    = 16'hF000;
  localparam logic [7:0]  DAA_LO_CORR = 8'h06;
  localparam logic [7:0]  DAA_HI_CORR = 8'h60;
  localparam logic [3:0]  BCD_MAX     = 4'd9;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_TICK  = 2'd1;
  localparam logic [1:0] FN_IRQ   = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;

  localparam logic [2:0] RSEL_M = 3'd6;
  localparam logic [2:0] RSEL_A = 3'd7;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [7:0] MASK_C7   = 8'hC7;
  localparam logic [7:0] MASK_CF   = 8'hCF;
  localparam logic [7:0] PAT_ALUI  = 8'hC6;
  localparam logic [7:0] PAT_INR   = 8'h04;
  localparam logic [7:0] PAT_DCR   = 8'h05;
  localparam logic [7:0] PAT_MVI   = 8'h06;
  localparam logic [7:0] PAT_LXI   = 8'h01;
  localparam logic [7:0] PAT_INX   = 8'h03;
  localparam logic [7:0] PAT_DCX   = 8'h0B;
  localparam logic [7:0] PAT_DAD   = 8'h09;
  localparam logic [7:0] PAT_RCC   = 8'hC0;
  localparam logic [7:0] PAT_JCC   = 8'hC2;
  localparam logic [7:0] PAT_CCC   = 8'hC4;
  localparam logic [7:0] PAT_RST   = 8'hC7;
  localparam logic [7:0] PAT_POP   = 8'hC1;
  localparam logic [7:0] PAT_PUSH  = 8'hC5;

  localparam logic [7:0] OP_HLT    = 8'h76;
  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_LDAX_B = 8'h0A;
  localparam logic [7:0] OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_SHLD   = 8'h22;
  localparam logic [7:0] OP_LHLD   = 8'h2A;
  localparam logic [7:0] OP_STA    = 8'h32;
  localparam logic [7:0] OP_LDA    = 8'h3A;
  localparam logic [7:0] OP_RLC    = 8'h07;
  localparam logic [7:0] OP_RRC    = 8'h0F;
  localparam logic [7:0] OP_RAL    = 8'h17;
  localparam logic [7:0] OP_RAR    = 8'h1F;
  localparam logic [7:0] OP_DAA    = 8'h27;
  localparam logic [7:0] OP_CMA    = 8'h2F;
  localparam logic [7:0] OP_STC    = 8'h37;
  localparam logic [7:0] OP_CMC    = 8'h3F;
  localparam logic [7:0] OP_JMP    = 8'hC3;
  localparam logic [7:0] OP_RET    = 8'hC9;
  localparam logic [7:0] OP_CALL   = 8'hCD;
  localparam logic [7:0] OP_OUT    = 8'hD3;
  localparam logic [7:0] OP_IN     = 8'hDB;
  localparam logic [7:0] OP_XTHL   = 8'hE3;
  localparam logic [7:0] OP_PCHL   = 8'hE9;
  localparam logic [7:0] OP_XCHG   = 8'hEB;
  localparam logic [7:0] OP_DI     = 8'hF3;
  localparam logic [7:0] OP_SPHL   = 8'hF9;
  localparam logic [7:0] OP_EI     = 8'hFB;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INT_LO, ST_FETCH, ST_DECODE, ST_IMM_LO, ST_IMM_HI, ST_EXEC,
    ST_RD_M, ST_PUSH_LO, ST_RD16_LO, ST_RD16_HI, ST_WR_HI, ST_DONE
  } state_t;

  typedef enum logic [5:0] {
    IC_NOP, IC_HLT, IC_MOV, IC_ALUR, IC_ALUI, IC_INR, IC_DCR, IC_MVI, IC_LXI,
    IC_INX, IC_DCX, IC_DAD, IC_RCC, IC_JCC, IC_CCC, IC_RST, IC_POP, IC_PUSH,
    IC_STAX, IC_LDAX, IC_SHLD, IC_LHLD, IC_STA, IC_LDA, IC_ROT, IC_DAA, IC_CMA,
    IC_STC, IC_CMC, IC_JMP, IC_RET, IC_CALL, IC_IO, IC_XTHL, IC_PCHL, IC_XCHG,
    IC_DI, IC_SPHL, IC_EI
  } ic_t;

  typedef enum logic [4:0] {
    ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBB, ALU_ANA, ALU_XRA, ALU_ORA, ALU_CMP,
    ALU_INR, ALU_DCR, ALU_RLC, ALU_RRC, ALU_RAL, ALU_RAR, ALU_DAA, ALU_CMA,
    ALU_STC, ALU_CMC
  } alu_op_t;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic c;
  } flags_t;

  function automatic ic_t op_class(input logic [7:0] op);
    ic_t c;
    c = IC_NOP;
    if (op == OP_HLT)                      c = IC_HLT;
    else if (op[7:6] == 2'b01)             c = IC_MOV;
    else if (op[7:6] == 2'b10)             c = IC_ALUR;
    else if ((op & MASK_C7) == PAT_ALUI)   c = IC_ALUI;
    else if ((op & MASK_C7) == PAT_INR)    c = IC_INR;
    else if ((op & MASK_C7) == PAT_DCR)    c = IC_DCR;
    else if ((op & MASK_C7) == PAT_MVI)    c = IC_MVI;
    else if ((op & MASK_CF) == PAT_LXI)    c = IC_LXI;
    else if ((op & MASK_CF) == PAT_INX)    c = IC_INX;
    else if ((op & MASK_CF) == PAT_DCX)    c = IC_DCX;
    else if ((op & MASK_CF) == PAT_DAD)    c = IC_DAD;
    else if ((op & MASK_C7) == PAT_RCC)    c = IC_RCC;
    else if ((op & MASK_C7) == PAT_JCC)    c = IC_JCC;
    else if ((op & MASK_C7) == PAT_CCC)    c = IC_CCC;
    else if ((op & MASK_C7) == PAT_RST)    c = IC_RST;
    else if ((op & MASK_CF) == PAT_POP)    c = IC_POP;
    else if ((op & MASK_CF) == PAT_PUSH)   c = IC_PUSH;
    else begin
      case (op)
        OP_STAX_B, OP_STAX_D:       c = IC_STAX;
        OP_LDAX_B, OP_LDAX_D:       c = IC_LDAX;
        OP_SHLD:                    c = IC_SHLD;
        OP_LHLD:                    c = IC_LHLD;
        OP_STA:                     c = IC_STA;
        OP_LDA:                     c = IC_LDA;
        OP_RLC, OP_RRC, OP_RAL, OP_RAR: c = IC_ROT;
        OP_DAA:                     c = IC_DAA;
        OP_CMA:                     c = IC_CMA;
        OP_STC:                     c = IC_STC;
        OP_CMC:                     c = IC_CMC;
        OP_JMP:                     c = IC_JMP;
        OP_RET:                     c = IC_RET;
        OP_CALL:                    c = IC_CALL;
        OP_OUT, OP_IN:              c = IC_IO;
        OP_XTHL:                    c = IC_XTHL;
        OP_PCHL:                    c = IC_PCHL;
        OP_XCHG:                    c = IC_XCHG;
        OP_DI:                      c = IC_DI;
        OP_SPHL:                    c = IC_SPHL;
        OP_EI:                      c = IC_EI;
        default:                    c = IC_NOP;
      endcase
    end
    return c;
  endfunction

  function automatic logic [1:0] imm_count(input ic_t c);
    logic [1:0] n;
    case (c)
      IC_MVI, IC_ALUI, IC_IO:                         n = 2'd1;
      IC_LXI, IC_SHLD, IC_LHLD, IC_STA, IC_LDA,
      IC_JMP, IC_JCC, IC_CALL, IC_CCC:                n = 2'd2;
      default:                                        n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* design/i80_alu.sv */
// Shared 8-bit arithmetic and logic unit with 8080 flag rules.
// Depends on i80_pkg for the operation code and the flag record.
`default_nettype none

module i80_alu import i80_pkg::*; (
  input  alu_op_t    op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  flags_t     fin,
  output logic [7:0] res,
  output flags_t     fout
);

  always_comb begin
    logic [7:0] y;
    logic       cin;
    logic [8:0] sum;
    logic [4:0] nib;
    logic [7:0] corr;
    logic       szp;
    corr = 8'h00;
    if (fin.ac || (a[3:0] > BCD_MAX)) corr = corr | DAA_LO_CORR;
    if (fin.c || (a[7:4] > BCD_MAX) || ((a[7:4] >= BCD_MAX) && (a[3:0] > BCD_MAX)))
      corr = corr | DAA_HI_CORR;
    case (op)
      ALU_ADD: begin y = b;     cin = 1'b0;    end
      ALU_ADC: begin y = b;     cin = fin.c;   end
      ALU_SUB, ALU_CMP: begin y = ~b; cin = 1'b1; end
      ALU_SBB: begin y = ~b;    cin = ~fin.c;  end
      ALU_INR: begin y = 8'h01; cin = 1'b0;    end
      ALU_DCR: begin y = 8'hFF; cin = 1'b0;    end
      ALU_DAA: begin y = corr;  cin = 1'b0;    end
      default: begin y = b;     cin = 1'b0;    end
    endcase
    sum  = {1'b0, a} + {1'b0, y} + {8'h00, cin};
    nib  = {1'b0, a[3:0]} + {1'b0, y[3:0]} + {4'h0, cin};
    fout = fin;
    res  = sum[7:0];
    szp  = 1'b1;
    case (op)
      ALU_ADD, ALU_ADC: begin fout.ac = nib[4]; fout.c = sum[8]; end
      ALU_DAA: begin fout.ac = nib[4]; fout.c = fin.c | corr[5]; end
      ALU_SUB, ALU_SBB, ALU_CMP: begin fout.ac = nib[4]; fout.c = ~sum[8]; end
      ALU_INR: fout.ac = (sum[3:0] == 4'h0);
      ALU_DCR: fout.ac = (sum[3:0] != 4'hF);
      ALU_ANA: begin res = a & b; fout.ac = a[3] | b[3]; fout.c = 1'b0; end
      ALU_XRA: begin res = a ^ b; fout.ac = 1'b0; fout.c = 1'b0; end
      ALU_ORA: begin res = a | b; fout.ac = 1'b0; fout.c = 1'b0; end
      ALU_RLC: begin res = {a[6:0], a[7]};  fout.c = a[7]; szp = 1'b0; end
      ALU_RRC: begin res = {a[0], a[7:1]};  fout.c = a[0]; szp = 1'b0; end
      ALU_RAL: begin res = {a[6:0], fin.c}; fout.c = a[7]; szp = 1'b0; end
      ALU_RAR: begin res = {fin.c, a[7:1]}; fout.c = a[0]; szp = 1'b0; end
      ALU_CMA: begin res = ~a; szp = 1'b0; end
      ALU_STC: begin res = a; fout.c = 1'b1; szp = 1'b0; end
      ALU_CMC: begin res = a; fout.c = ~fin.c; szp = 1'b0; end
      default: szp = 1'b0;
    endcase
    if (szp) begin
      fout.s = res[7];
      fout.z = (res == 8'h00);
      fout.p = ~^res;
    end
  end

endmodule

`default_nettype wire

/* design/i8080_instruction_core_unit.sv */
// 8080 instruction core: sequencer, register file and private byte memory.
// Depends on i80_pkg and i80_alu.
// One beat in gives one beat out. A load beat writes one byte. A tick walks the single-port
// memory one access per cycle: an executed instruction makes its fetch, operand bytes, then
// data or stack accesses, and a queued restart first pushes the program counter. The input
// stalls from acceptance until the result beat has been taken.
`default_nettype none

module i8080_instruction_core_unit import i80_pkg::*; #(
  parameter int MEM_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pc_now,
  output logic [15:0]      out_sp_now,
  output logic [7:0]       out_acc_now,
  output logic [7:0]       out_psw_flags,
  output logic [15:0]      out_pair_bc,
  output logic [15:0]      out_pair_de,
  output logic [15:0]      out_pair_hl,
  output logic             out_is_halted,
  output logic             out_ints_on,
  output logic             out_int_accepted
);

  localparam int AW = $clog2(MEM_DEPTH);

  state_t      state_r, state_nxt;
  logic [15:0] pc_r, pc_nxt, sp_r, sp_nxt;
  logic [7:0]  a_r, a_nxt;
  flags_t      f_r, f_nxt;
  logic [15:0] bc_r, bc_nxt, de_r, de_nxt, hl_r, hl_nxt;
  logic        ie_r, ie_nxt, eip_r, eip_nxt, ipend_r, ipend_nxt, halt_r, halt_nxt;
  logic [7:0]  ivec_r, ivec_nxt;
  logic        iacc_r, iacc_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [15:0] w_r, w_nxt, x_r, x_nxt;

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wd;

  ic_t         cls;
  logic [2:0]  fd, fs;
  logic [1:0]  fp;
  logic [7:0]  rd_d, rd_s, opnd, alu_a, alu_res;
  logic [15:0] rp_v;
  logic        cond_ok;
  alu_op_t     alu_op;
  flags_t      alu_fl;
  logic [16:0] dad_sum;

  logic        rw_en;
  logic [2:0]  rw_sel;
  logic [7:0]  rw_val;
  logic        rpw_en;
  logic [15:0] rpw_val;

  function automatic logic [7:0] r8(input logic [2:0] sel, input logic [15:0] bc,
                                    input logic [15:0] de, input logic [15:0] hl,
                                    input logic [7:0] acc);
    logic [7:0] v;
    case (sel)
      3'd0:    v = bc[15:8];
      3'd1:    v = bc[7:0];
      3'd2:    v = de[15:8];
      3'd3:    v = de[7:0];
      3'd4:    v = hl[15:8];
      3'd5:    v = hl[7:0];
      default: v = acc;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr[AW-1:0]] <= mem_wd;
    mem_q <= mem[mem_addr[AW-1:0]];
  end

  assign cls  = op_class(op_r);
  assign fd   = op_r[5:3];
  assign fs   = op_r[2:0];
  assign fp   = op_r[5:4];
  assign rd_d = r8(fd, bc_r, de_r, hl_r, a_r);
  assign rd_s = r8(fs, bc_r, de_r, hl_r, a_r);

  always_comb begin
    case (fp)
      2'd0:    rp_v = bc_r;
      2'd1:    rp_v = de_r;
      2'd2:    rp_v = hl_r;
      default: rp_v = sp_r;
    endcase
    case (fd[2:1])
      2'd0:    cond_ok = f_r.z;
      2'd1:    cond_ok = f_r.c;
      2'd2:    cond_ok = f_r.p;
      default: cond_ok = f_r.s;
    endcase
    if (!fd[0]) cond_ok = ~cond_ok;
  end

  always_comb begin
    case (cls)
      IC_ALUR, IC_ALUI: alu_op = alu_op_t'({2'b00, fd});
      IC_INR:           alu_op = ALU_INR;
      IC_DCR:           alu_op = ALU_DCR;
      IC_DAA:           alu_op = ALU_DAA;
      IC_CMA:           alu_op = ALU_CMA;
      IC_STC:           alu_op = ALU_STC;
      IC_CMC:           alu_op = ALU_CMC;
      IC_ROT: begin
        case (op_r[4:3])
          2'd0:    alu_op = ALU_RLC;
          2'd1:    alu_op = ALU_RRC;
          2'd2:    alu_op = ALU_RAL;
          default: alu_op = ALU_RAR;
        endcase
      end
      default:          alu_op = ALU_ADD;
    endcase
    if (state_r == ST_RD_M)                 opnd = mem_q;
    else if (cls == IC_ALUI)                opnd = w_r[7:0];
    else if (cls == IC_INR || cls == IC_DCR) opnd = rd_d;
    else                                    opnd = rd_s;
    alu_a = (cls == IC_INR || cls == IC_DCR) ? opnd : a_r;
  end

  i80_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (opnd),
    .fin  (f_r),
    .res  (alu_res),
    .fout (alu_fl)
  );

  assign dad_sum = {1'b0, hl_r} + {1'b0, rp_v};

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;  sp_nxt = sp_r;  a_nxt = a_r;  f_nxt = f_r;
    bc_nxt = bc_r;  de_nxt = de_r;  hl_nxt = hl_r;
    ie_nxt = ie_r;  eip_nxt = eip_r;  ipend_nxt = ipend_r;  halt_nxt = halt_r;
    ivec_nxt = ivec_r;  iacc_nxt = iacc_r;
    op_nxt = op_r;  w_nxt = w_r;  x_nxt = x_r;
    mem_we = 1'b0;  mem_addr = pc_r;  mem_wd = a_r;
    rw_en = 1'b0;  rw_sel = fd;  rw_val = alu_res;
    rpw_en = 1'b0;  rpw_val = w_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          iacc_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (in_func)
            FN_LOAD: begin
              mem_we = 1'b1;  mem_addr = in_address;  mem_wd = in_data;
            end
            FN_TICK: begin
              ie_nxt  = ie_r | eip_r;
              eip_nxt = 1'b0;
              if (ipend_r) begin
                ipend_nxt = 1'b0;
                mem_we = 1'b1;  mem_addr = sp_r - 16'd1;  mem_wd = pc_r[15:8];
                sp_nxt = sp_r - 16'd1;
                state_nxt = ST_INT_LO;
              end else if (!halt_r) begin
                mem_addr = pc_r;  pc_nxt = pc_r + 16'd1;
                state_nxt = ST_DECODE;
              end
            end
            FN_IRQ: begin
              halt_nxt = 1'b0;
              iacc_nxt = ie_r;
              if (ie_r) begin
                ie_nxt = 1'b0;  ipend_nxt = 1'b1;  ivec_nxt = in_data;
              end
            end
            default: ;
          endcase
        end
      end

      ST_INT_LO: begin
        mem_we = 1'b1;  mem_addr = sp_r - 16'd1;  mem_wd = pc_r[7:0];
        sp_nxt = sp_r - 16'd1;
        pc_nxt = {5'b00000, ivec_r, 3'b000};
        state_nxt = halt_r ? ST_DONE : ST_FETCH;
      end

      ST_FETCH: begin
        mem_addr = pc_r;  pc_nxt = pc_r + 16'd1;
        state_nxt = ST_DECODE;
      end

      ST_DECODE: begin
        op_nxt = mem_q;
        if (imm_count(op_class(mem_q)) != 2'd0) begin
          mem_addr = pc_r;  pc_nxt = pc_r + 16'd1;
          state_nxt = ST_IMM_LO;
        end else begin
          state_nxt = ST_EXEC;
        end
      end

      ST_IMM_LO: begin
        w_nxt = {w_r[15:8], mem_q};
        if (imm_count(cls) == 2'd2) begin
          mem_addr = pc_r;  pc_nxt = pc_r + 16'd1;
          state_nxt = ST_IMM_HI;
        end else begin
          state_nxt = ST_EXEC;
        end
      end

      ST_IMM_HI: begin
        w_nxt = {mem_q, w_r[7:0]};
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (cls)
          IC_HLT: halt_nxt = 1'b1;
          IC_MOV: begin
            if (fs == RSEL_M) begin
              mem_addr = hl_r;  state_nxt = ST_RD_M;
            end else if (fd == RSEL_M) begin
              mem_we = 1'b1;  mem_addr = hl_r;  mem_wd = rd_s;
            end else begin
              rw_en = 1'b1;  rw_val = rd_s;
            end
          end
          IC_ALUR, IC_ALUI: begin
            if (cls == IC_ALUR && fs == RSEL_M) begin
              mem_addr = hl_r;  state_nxt = ST_RD_M;
            end else begin
              f_nxt = alu_fl;
              if (alu_op != ALU_CMP) a_nxt = alu_res;
            end
          end
          IC_INR, IC_DCR: begin
            if (fd == RSEL_M) begin
              mem_addr = hl_r;  state_nxt = ST_RD_M;
            end else begin
              f_nxt = alu_fl;  rw_en = 1'b1;
            end
          end
          IC_MVI: begin
            if (fd == RSEL_M) begin
              mem_we = 1'b1;  mem_addr = hl_r;  mem_wd = w_r[7:0];
            end else begin
              rw_en = 1'b1;  rw_val = w_r[7:0];
            end
          end
          IC_LXI: rpw_en = 1'b1;
          IC_INX: begin rpw_en = 1'b1;  rpw_val = rp_v + 16'd1; end
          IC_DCX: begin rpw_en = 1'b1;  rpw_val = rp_v - 16'd1; end
          IC_DAD: begin hl_nxt = dad_sum[15:0];  f_nxt.c = dad_sum[16]; end
          IC_RCC, IC_RET: begin
            if (cls == IC_RET || cond_ok) begin
              mem_addr = sp_r;  sp_nxt = sp_r + 16'd1;  state_nxt = ST_RD16_LO;
            end
          end
          IC_POP: begin
            mem_addr = sp_r;  sp_nxt = sp_r + 16'd1;  state_nxt = ST_RD16_LO;
          end
          IC_JCC: if (cond_ok) pc_nxt = w_r;
          IC_JMP: pc_nxt = w_r;
          IC_CCC, IC_CALL, IC_RST: begin
            if (cls != IC_CCC || cond_ok) begin
              if (cls == IC_RST) w_nxt = {10'h000, fd, 3'b000};
              x_nxt = pc_r;
              mem_we = 1'b1;  mem_addr = sp_r - 16'd1;  mem_wd = pc_r[15:8];
              sp_nxt = sp_r - 16'd1;  state_nxt = ST_PUSH_LO;
            end
          end
          IC_PUSH: begin
            mem_we = 1'b1;  mem_addr = sp_r - 16'd1;
            if (fp == PAIR_SP) begin
              x_nxt  = {a_r, f_r.s, f_r.z, 1'b0, f_r.ac, 1'b0, f_r.p, 1'b1, f_r.c};
              mem_wd = a_r;
            end else begin
              x_nxt  = rp_v;
              mem_wd = rp_v[15:8];
            end
            sp_nxt = sp_r - 16'd1;  state_nxt = ST_PUSH_LO;
          end
          IC_STAX: begin
            mem_we = 1'b1;  mem_addr = op_r[4] ? de_r : bc_r;  mem_wd = a_r;
          end
          IC_LDAX: begin
            mem_addr = op_r[4] ? de_r : bc_r;  state_nxt = ST_RD_M;
          end
          IC_STA: begin
            mem_we = 1'b1;  mem_addr = w_r;  mem_wd = a_r;
          end
          IC_LDA: begin
            mem_addr = w_r;  state_nxt = ST_RD_M;
          end
          IC_SHLD: begin
            mem_we = 1'b1;  mem_addr = w_r;  mem_wd = hl_r[7:0];  state_nxt = ST_WR_HI;
          end
          IC_LHLD: begin
            mem_addr = w_r;  state_nxt = ST_RD16_LO;
          end
          IC_XTHL: begin
            mem_addr = sp_r;  state_nxt = ST_RD16_LO;
          end
          IC_ROT, IC_DAA, IC_CMA: begin
            a_nxt = alu_res;  f_nxt = alu_fl;
          end
          IC_STC, IC_CMC: f_nxt = alu_fl;
          IC_PCHL: pc_nxt = hl_r;
          IC_XCHG: begin hl_nxt = de_r;  de_nxt = hl_r; end
          IC_DI:   begin ie_nxt = 1'b0;  eip_nxt = 1'b0; end
          IC_EI:   eip_nxt = 1'b1;
          IC_SPHL: sp_nxt = hl_r;
          default: ;
        endcase
      end

      ST_RD_M: begin
        state_nxt = ST_DONE;
        case (cls)
          IC_MOV: begin rw_en = 1'b1;  rw_val = mem_q; end
          IC_ALUR: begin
            f_nxt = alu_fl;
            if (alu_op != ALU_CMP) a_nxt = alu_res;
          end
          IC_INR, IC_DCR: begin
            f_nxt = alu_fl;
            mem_we = 1'b1;  mem_addr = hl_r;  mem_wd = alu_res;
          end
          IC_LDAX, IC_LDA: a_nxt = mem_q;
          default: ;
        endcase
      end

      ST_PUSH_LO: begin
        mem_we = 1'b1;  mem_addr = sp_r - 16'd1;  mem_wd = x_r[7:0];
        sp_nxt = sp_r - 16'd1;
        if (cls != IC_PUSH) pc_nxt = w_r;
        state_nxt = ST_DONE;
      end

      ST_RD16_LO: begin
        x_nxt = {x_r[15:8], mem_q};
        if (cls == IC_LHLD) begin
          mem_addr = w_r + 16'd1;
        end else if (cls == IC_XTHL) begin
          mem_addr = sp_r + 16'd1;
        end else begin
          mem_addr = sp_r;  sp_nxt = sp_r + 16'd1;
        end
        state_nxt = ST_RD16_HI;
      end

      ST_RD16_HI: begin
        state_nxt = ST_DONE;
        case (cls)
          IC_RET, IC_RCC: pc_nxt = {mem_q, x_r[7:0]};
          IC_LHLD:        hl_nxt = {mem_q, x_r[7:0]};
          IC_POP: begin
            if (fp == PAIR_SP) begin
              a_nxt = mem_q;
              f_nxt = '{s: x_r[7], z: x_r[6], ac: x_r[4], p: x_r[2], c: x_r[0]};
            end else begin
              rpw_en = 1'b1;  rpw_val = {mem_q, x_r[7:0]};
            end
          end
          IC_XTHL: begin
            x_nxt = {mem_q, x_r[7:0]};
            mem_we = 1'b1;  mem_addr = sp_r;  mem_wd = hl_r[7:0];
            state_nxt = ST_WR_HI;
          end
          default: ;
        endcase
      end

      ST_WR_HI: begin
        mem_we = 1'b1;
        mem_addr = ((cls == IC_XTHL) ? sp_r : w_r) + 16'd1;
        mem_wd = hl_r[15:8];
        if (cls == IC_XTHL) hl_nxt = x_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;

      default: state_nxt = ST_IDLE;
    endcase

    if (rw_en) begin
      case (rw_sel)
        3'd0:    bc_nxt[15:8] = rw_val;
        3'd1:    bc_nxt[7:0]  = rw_val;
        3'd2:    de_nxt[15:8] = rw_val;
        3'd3:    de_nxt[7:0]  = rw_val;
        3'd4:    hl_nxt[15:8] = rw_val;
        3'd5:    hl_nxt[7:0]  = rw_val;
        RSEL_A:  a_nxt        = rw_val;
        default: ;
      endcase
    end
    if (rpw_en) begin
      case (fp)
        2'd0:    bc_nxt = rpw_val;
        2'd1:    de_nxt = rpw_val;
        2'd2:    hl_nxt = rpw_val;
        default: sp_nxt = rpw_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= 16'h0000;
      sp_r    <= SP_RESET;
      a_r     <= 8'h00;
      f_r     <= '0;
      bc_r    <= 16'h0000;
      de_r    <= 16'h0000;
      hl_r    <= 16'h0000;
      ie_r    <= 1'b0;
      eip_r   <= 1'b0;
      ipend_r <= 1'b0;
      ivec_r  <= 8'h00;
      halt_r  <= 1'b0;
      iacc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      a_r     <= a_nxt;
      f_r     <= f_nxt;
      bc_r    <= bc_nxt;
      de_r    <= de_nxt;
      hl_r    <= hl_nxt;
      ie_r    <= ie_nxt;
      eip_r   <= eip_nxt;
      ipend_r <= ipend_nxt;
      ivec_r  <= ivec_nxt;
      halt_r  <= halt_nxt;
      iacc_r  <= iacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    w_r  <= w_nxt;
    x_r  <= x_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_pc_now       = pc_r;
  assign out_sp_now       = sp_r;
  assign out_acc_now      = a_r;
  assign out_psw_flags    = {f_r.s, f_r.z, 1'b0, f_r.ac, 1'b0, f_r.p, 1'b1, f_r.c};
  assign out_pair_bc      = bc_r;
  assign out_pair_de      = de_r;
  assign out_pair_hl      = hl_r;
  assign out_is_halted    = halt_r;
  assign out_ints_on      = ie_r;
  assign out_int_accepted = iacc_r;

endmodule

`default_nettype wire
